// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the event qualifier.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define CCEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define CCEQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  `CCEQ_ASSERT(lbl, clk, rst_n, (pre) |=> (post), msg)

`endif

// File: hw/rtl/cceq_pkg.sv
// Package of the color class event qualifier: widths, reset values,
// register indexes, class and event codes, configuration and result types.
package cceq_pkg;

  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned LimitWidth    = 24;
  localparam int unsigned PlayWidth     = 48;
  localparam int unsigned IntervalWidth = 16;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 48;
  localparam int unsigned CmpWidth      = (TimeWidth > LimitWidth) ? TimeWidth : LimitWidth;

  localparam logic [LimitWidth-1:0]    RedLimitsRst      = 24'd13127760;
  localparam logic [LimitWidth-1:0]    BlueLimitsRst     = 24'd5263560;
  localparam logic [LimitWidth-1:0]    YellowLimitsRst   = 24'd13158480;
  localparam logic [PlayWidth-1:0]     PlayTableRst      = 48'd0;
  localparam logic [LimitWidth-1:0]    ChangeDelayRst    = 24'd100;
  localparam logic [LimitWidth-1:0]    NoneTimeoutRst    = 24'd6000;
  localparam logic [IntervalWidth-1:0] ReportIntervalRst = 16'd10;

  localparam logic [7:0] StopPatternId = 8'd4;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgRedLimits      = 3'd0,
    CfgBlueLimits     = 3'd1,
    CfgYellowLimits   = 3'd2,
    CfgPlayTable      = 3'd3,
    CfgChangeDelay    = 3'd4,
    CfgNoneTimeout    = 3'd5,
    CfgReportInterval = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ClsRed    = 2'd0,
    ClsBlue   = 2'd1,
    ClsYellow = 2'd2,
    ClsNone   = 2'd3
  } color_class_e;

  typedef enum logic [1:0] {
    EvNone = 2'd0,
    EvPlay = 2'd1,
    EvStop = 2'd2
  } event_kind_e;

  typedef struct packed {
    logic [LimitWidth-1:0]    red_limits;
    logic [LimitWidth-1:0]    blue_limits;
    logic [LimitWidth-1:0]    yellow_limits;
    logic [PlayWidth-1:0]     play_table;
    logic [LimitWidth-1:0]    change_delay;
    logic [LimitWidth-1:0]    none_timeout;
    logic [IntervalWidth-1:0] report_interval;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    event_kind_e  kind;
    logic [1:0]   color;
    logic [7:0]   pattern_id;
    logic [7:0]   volume;
    color_class_e cls;
    logic         report_valid;
    rgb_t         report;
  } res_t;

endpackage

// File: hw/rtl/cceq_ifs.sv
// Valid/ready stream interfaces for sensor samples and qualifier results.
// No dependencies.
interface cceq_sample_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface cceq_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [1:0] event_color;
  logic [7:0] pattern_id;
  logic [7:0] volume;
  logic [1:0] class_now;
  logic       report_valid;
  logic [7:0] report_red;
  logic [7:0] report_green;
  logic [7:0] report_blue;

  modport source (output valid, output event_kind, output event_color, output pattern_id,
                  output volume, output class_now, output report_valid, output report_red,
                  output report_green, output report_blue, input ready);
  modport sink   (input valid, input event_kind, input event_color, input pattern_id,
                  input volume, input class_now, input report_valid, input report_red,
                  input report_green, input report_blue, output ready);
endinterface

// File: hw/rtl/cceq_cfg_regs.sv
// Configuration register file of the event qualifier.
// Depends on cceq_pkg.
module cceq_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [cceq_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [cceq_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  output cceq_pkg::cfg_t                       cfg_o
);

  cceq_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_limits      <= cceq_pkg::RedLimitsRst;
      cfg_q.blue_limits     <= cceq_pkg::BlueLimitsRst;
      cfg_q.yellow_limits   <= cceq_pkg::YellowLimitsRst;
      cfg_q.play_table      <= cceq_pkg::PlayTableRst;
      cfg_q.change_delay    <= cceq_pkg::ChangeDelayRst;
      cfg_q.none_timeout    <= cceq_pkg::NoneTimeoutRst;
      cfg_q.report_interval <= cceq_pkg::ReportIntervalRst;
    end else if (cfg_we_i) begin
      unique case (cceq_pkg::cfg_idx_e'(cfg_idx_i))
        cceq_pkg::CfgRedLimits: begin
          cfg_q.red_limits <= cfg_wdata_i[cceq_pkg::LimitWidth-1:0];
        end
        cceq_pkg::CfgBlueLimits: begin
          cfg_q.blue_limits <= cfg_wdata_i[cceq_pkg::LimitWidth-1:0];
        end
        cceq_pkg::CfgYellowLimits: begin
          cfg_q.yellow_limits <= cfg_wdata_i[cceq_pkg::LimitWidth-1:0];
        end
        cceq_pkg::CfgPlayTable: begin
          cfg_q.play_table <= cfg_wdata_i[cceq_pkg::PlayWidth-1:0];
        end
        cceq_pkg::CfgChangeDelay: begin
          cfg_q.change_delay <= cfg_wdata_i[cceq_pkg::LimitWidth-1:0];
        end
        cceq_pkg::CfgNoneTimeout: begin
          cfg_q.none_timeout <= cfg_wdata_i[cceq_pkg::LimitWidth-1:0];
        end
        cceq_pkg::CfgReportInterval: begin
          cfg_q.report_interval <= cfg_wdata_i[cceq_pkg::IntervalWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/cceq_classify.sv
// Color classifier: inclusive threshold boxes tested red, blue, yellow.
// Depends on cceq_pkg.
module cceq_classify (
  input  cceq_pkg::rgb_t         rgb_i,
  input  cceq_pkg::cfg_t         cfg_i,
  output cceq_pkg::color_class_e cls_o
);

  logic is_red, is_blue, is_yellow;

  assign is_red    = (rgb_i.red   >= cfg_i.red_limits[23:16]) &&
                     (rgb_i.green <= cfg_i.red_limits[15:8]) &&
                     (rgb_i.blue  <= cfg_i.red_limits[7:0]);
  assign is_blue   = (rgb_i.red   <= cfg_i.blue_limits[23:16]) &&
                     (rgb_i.green <= cfg_i.blue_limits[15:8]) &&
                     (rgb_i.blue  >= cfg_i.blue_limits[7:0]);
  assign is_yellow = (rgb_i.red   >= cfg_i.yellow_limits[23:16]) &&
                     (rgb_i.green >= cfg_i.yellow_limits[15:8]) &&
                     (rgb_i.blue  <= cfg_i.yellow_limits[7:0]);

  always_comb begin
    priority if (is_red) begin
      cls_o = cceq_pkg::ClsRed;
    end else if (is_blue) begin
      cls_o = cceq_pkg::ClsBlue;
    end else if (is_yellow) begin
      cls_o = cceq_pkg::ClsYellow;
    end else begin
      cls_o = cceq_pkg::ClsNone;
    end
  end

endmodule

// File: hw/rtl/cceq_qualify.sv
// Event qualifier state: sample clock, change and none stamps, stop flag
// and report counter; forms the next result. Depends on cceq_pkg.
module cceq_qualify (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   advance_i,
  input  cceq_pkg::color_class_e cls_i,
  input  cceq_pkg::rgb_t         rgb_i,
  input  cceq_pkg::cfg_t         cfg_i,
  output cceq_pkg::res_t         res_o
);

  localparam int unsigned TW = cceq_pkg::TimeWidth;
  localparam int unsigned CW = cceq_pkg::CmpWidth;
  localparam int unsigned LW = cceq_pkg::LimitWidth;
  localparam int unsigned IW = cceq_pkg::IntervalWidth;

  function automatic logic time_reached(logic [TW-1:0] elapsed, logic [LW-1:0] limit);
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    a = CW'(elapsed);
    b = CW'(limit);
    return a >= b;
  endfunction

  cceq_pkg::color_class_e prev_cls_q, prev_cls_d;
  cceq_pkg::color_class_e last_sent_q, last_sent_d;
  logic [TW-1:0]          clock_q, clock_d;
  logic [TW-1:0]          change_stamp_q, change_stamp_d;
  logic [TW-1:0]          none_stamp_q, none_stamp_d;
  logic                   stop_sent_q, stop_sent_d;
  logic [IW-1:0]          report_cnt_q, report_cnt_d;

  logic [TW-1:0] since_change;
  logic [TW-1:0] since_none;
  logic [IW-1:0] report_inc;
  logic [15:0]   play_slot;

  assign since_change = clock_q - change_stamp_q;
  assign since_none   = clock_q - none_stamp_d;
  assign report_inc   = report_cnt_q + IW'(1);

  always_comb begin
    unique case (cls_i)
      cceq_pkg::ClsRed:    play_slot = cfg_i.play_table[15:0];
      cceq_pkg::ClsBlue:   play_slot = cfg_i.play_table[31:16];
      cceq_pkg::ClsYellow: play_slot = cfg_i.play_table[47:32];
      default:             play_slot = 16'd0;
    endcase
  end

  always_comb begin
    prev_cls_d     = cls_i;
    last_sent_d    = last_sent_q;
    clock_d        = clock_q + TW'(1);
    change_stamp_d = change_stamp_q;
    none_stamp_d   = none_stamp_q;
    stop_sent_d    = stop_sent_q;
    res_o          = '0;
    res_o.kind     = cceq_pkg::EvNone;
    res_o.cls      = cls_i;

    if (cls_i != prev_cls_q) begin
      if (cls_i != cceq_pkg::ClsNone) begin
        stop_sent_d  = 1'b0;
        none_stamp_d = '0;
        if (last_sent_q != cls_i || time_reached(since_change, cfg_i.change_delay)) begin
          res_o.kind       = cceq_pkg::EvPlay;
          res_o.color      = cls_i;
          res_o.pattern_id = play_slot[7:0];
          res_o.volume     = play_slot[15:8];
          last_sent_d      = cls_i;
          change_stamp_d   = clock_q;
        end
      end else begin
        change_stamp_d = clock_q;
        if (!stop_sent_q) begin
          none_stamp_d = clock_q;
        end
      end
    end

    if (cls_i == cceq_pkg::ClsNone && !stop_sent_d &&
        time_reached(since_none, cfg_i.none_timeout)) begin
      res_o.kind       = cceq_pkg::EvStop;
      res_o.color      = 2'd0;
      res_o.pattern_id = cceq_pkg::StopPatternId;
      res_o.volume     = 8'd0;
      stop_sent_d      = 1'b1;
    end

    if (report_inc >= cfg_i.report_interval) begin
      res_o.report_valid = 1'b1;
      res_o.report       = rgb_i;
      report_cnt_d       = '0;
    end else begin
      report_cnt_d = report_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_cls_q     <= cceq_pkg::ClsNone;
      last_sent_q    <= cceq_pkg::ClsNone;
      clock_q        <= '0;
      change_stamp_q <= '0;
      none_stamp_q   <= '0;
      stop_sent_q    <= 1'b0;
      report_cnt_q   <= '0;
    end else if (advance_i) begin
      prev_cls_q     <= prev_cls_d;
      last_sent_q    <= last_sent_d;
      clock_q        <= clock_d;
      change_stamp_q <= change_stamp_d;
      none_stamp_q   <= none_stamp_d;
      stop_sent_q    <= stop_sent_d;
      report_cnt_q   <= report_cnt_d;
    end
  end

endmodule

// File: hw/rtl/color_class_event_qualifier_unit.sv
// Color class event qualifier, top level: sample input register, classifier,
// qualifier state and result register. Depends on cceq_pkg, cceq_ifs,
// cceq_cfg_regs, cceq_classify, cceq_qualify and assert_macros.svh.
//
// Usage:
//   sample_i takes one RGB sensor sample per transfer (valid/ready).
//   result_o gives exactly one result per sample, in order: event kind,
//   event color, pattern id, volume, the sample's class and an optional
//   raw RGB report.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write one register per cycle; write only
//   while no sample is in flight.
// Path: a transferred sample is held in the input register; its result is
//   registered in the result register once that is free and is offered from
//   then on until the receiver takes it.
// Throughput: one sample per cycle while results are taken; the classify and
//   qualify logic between the input and result registers is a single pass.
// Reset: configuration returns to its defaults, sample clock, stamps, stop
//   flag and report counter clear, both registers empty.
// Stall: a result held by the receiver keeps the input register loaded; one
//   more sample is taken into it and then sample_i.ready drops.
module color_class_event_qualifier_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  cceq_sample_if.sink                       sample_i,
  cceq_result_if.source                     result_o,
  input  logic                              cfg_we_i,
  input  logic [cceq_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [cceq_pkg::CfgDataWidth-1:0] cfg_wdata_i
);

  `include "assert_macros.svh"

  cceq_pkg::cfg_t         cfg;
  cceq_pkg::color_class_e cls;
  cceq_pkg::res_t         res_d, res_q;
  cceq_pkg::rgb_t         s1_rgb_q;
  logic                   s1_valid_q;
  logic                   out_valid_q;
  logic                   out_free;
  logic                   advance;
  logic                   in_xfer;

  assign out_free       = !out_valid_q || result_o.ready;
  assign advance        = s1_valid_q && out_free;
  assign sample_i.ready = !s1_valid_q || out_free;
  assign in_xfer        = sample_i.valid && sample_i.ready;

  cceq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cceq_classify u_classify (
    .rgb_i (s1_rgb_q),
    .cfg_i (cfg),
    .cls_o (cls)
  );

  cceq_qualify u_qualify (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .cls_i     (cls),
    .rgb_i     (s1_rgb_q),
    .cfg_i     (cfg),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_rgb_q.red   <= sample_i.red;
      s1_rgb_q.green <= sample_i.green;
      s1_rgb_q.blue  <= sample_i.blue;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.event_kind   = res_q.kind;
  assign result_o.event_color  = res_q.color;
  assign result_o.pattern_id   = res_q.pattern_id;
  assign result_o.volume       = res_q.volume;
  assign result_o.class_now    = res_q.cls;
  assign result_o.report_valid = res_q.report_valid;
  assign result_o.report_red   = res_q.report.red;
  assign result_o.report_green = res_q.report.green;
  assign result_o.report_blue  = res_q.report.blue;

  `CCEQ_ASSERT(a_stop_payload, clk_i, rst_ni,
    out_valid_q && res_q.kind == cceq_pkg::EvStop |->
      res_q.pattern_id == cceq_pkg::StopPatternId && res_q.volume == 8'd0 &&
      res_q.color == 2'd0,
    "stop event carries wrong payload")
  `CCEQ_ASSERT(a_play_color, clk_i, rst_ni,
    out_valid_q && res_q.kind == cceq_pkg::EvPlay |->
      res_q.color == res_q.cls && res_q.cls != cceq_pkg::ClsNone,
    "play event color differs from sample class")
  `CCEQ_ASSERT(a_report_zero, clk_i, rst_ni,
    out_valid_q && !res_q.report_valid |-> res_q.report == '0,
    "report fields nonzero without report")
  `CCEQ_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni,
    s1_valid_q && !advance, s1_valid_q && $stable(s1_rgb_q),
    "input register lost sample during stall")

endmodule
